### rtl/armn_pkg.sv
package armn_pkg;

    localparam int COL_W = 7;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FIRST = 2'd1,
        OP_NEXT  = 2'd2,
        OP_NONE  = 2'd3
    } op_e;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  row_vertex;
        logic [5:0]  other_vertex;
        logic [31:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [5:0] neighbour;
        logic       found;
    } out_item_t;

    typedef struct packed {
        logic             clear;
        logic             load_floor;
        logic             has_floor;
        logic             cmp_vld;
        logic [COL_W-1:0] col;
    } scan_ctrl_t;

endpackage

### rtl/armn_mem.sv
module armn_mem
    #(
        parameter int DEPTH = 4096,
        parameter int AW    = 12,
        parameter int DW    = 32
    )
    (
        input  logic          clk,
        input  logic          we,
        input  logic [AW-1:0] addr,
        input  logic [DW-1:0] wdata,
        output logic [DW-1:0] rdata
    );

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/armn_scan.sv
module armn_scan
    import armn_pkg::*;
    #(
        parameter int WEIGHT_BITS = 32
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        input  scan_ctrl_t             ctrl,
        input  logic [WEIGHT_BITS-1:0] rdata,
        output out_item_t              result
    );

    logic [WEIGHT_BITS-1:0] floor_reg;
    logic [WEIGHT_BITS-1:0] best_reg;
    logic [COL_W-1:0]       pick_reg;
    logic                   hit_reg;
    logic                   take;

    // all-ones weight never qualifies since best starts there and compare is strict
    assign take = ctrl.cmp_vld && (!ctrl.has_floor || (rdata > floor_reg))
                  && (rdata < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            pick_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else if (take)
        begin
            pick_reg <= ctrl.col;
            hit_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            best_reg <= '1;
        end
        else if (take)
        begin
            best_reg <= rdata;
        end
        if (ctrl.load_floor)
        begin
            floor_reg <= rdata;
        end
    end

    assign result.neighbour = pick_reg[5:0];
    assign result.found     = hit_reg;

endmodule

### rtl/adjacency_row_min_neighbour_unit.sv
// Minimum-edge search over a square weight matrix held in on-chip RAM.
// Input channel: an item is taken at a clock edge with start high and busy low.
//   operation 0 writes one weight; 1 returns the lightest neighbour of row_vertex;
//   2 returns the lightest neighbour heavier than the entry at other_vertex.
//   Operation 3 is dropped and leaves busy low.
// Result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall it, and nothing waits on it.
// Config channel: cfg_data (vertex count) is taken when cfg_valid is high;
//   cfg_ready is always high. Write it only while busy is low.
// Sequencing, with n = min(vertex count, MAX_VERTICES):
//   write: S_WRITE stores the weight, then the unit returns to idle.
//   first query: S_SCAN over columns 0 to n-1, then S_DONE, then idle.
//   next query: S_FLOOR and S_FLOAD read the reference entry, then S_SCAN, S_DONE.
//   The row scan reads one matrix entry per cycle through the single RAM port.
// Reset: control clears, vertex count returns to 64; matrix contents are kept
//   and are undefined until written.
module adjacency_row_min_neighbour_unit
    import armn_pkg::*;
    #(
        parameter int MAX_VERTICES = 64,
        parameter int WEIGHT_BITS  = 32
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             start,
        output logic             busy,
        input  in_item_t         item,
        output logic             done,
        output out_item_t        result,
        input  logic             cfg_valid,
        output logic             cfg_ready,
        input  logic [COL_W-1:0] cfg_data
    );

    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(CELLS);
    localparam int FW    = AW + COL_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_FLOOR = 6'b000100,
        S_FLOAD = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    in_item_t         item_reg;
    logic [COL_W-1:0] vcount_reg;
    logic [COL_W-1:0] n_reg, n_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [COL_W-1:0] pend_col_reg, pend_col_next;
    logic             accept;
    logic             row_ok;
    logic             other_ok;
    logic [COL_W-1:0] col_sel;
    logic [FW-1:0]    addr_full;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;
    logic [63:0]      wdata_ext;
    logic [WEIGHT_BITS-1:0] mem_rdata;
    scan_ctrl_t       ctrl;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign cfg_ready = 1'b1;

    assign row_ok   = int'(item.row_vertex) < MAX_VERTICES;
    assign other_ok = int'(item.other_vertex) < MAX_VERTICES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= COL_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            vcount_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        col_next      = col_reg;
        pend_vld_next = 1'b0;
        pend_col_next = pend_col_reg;
        ctrl          = '0;
        ctrl.has_floor = (item_reg.operation == OP_NEXT);
        ctrl.cmp_vld   = pend_vld_reg;
        ctrl.col       = pend_col_reg;
        mem_we        = 1'b0;
        col_sel       = {1'b0, item_reg.other_vertex};
        n_next = (int'(vcount_reg) > MAX_VERTICES) ? COL_W'(MAX_VERTICES) : vcount_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                col_next = '0;
                if (accept)
                begin
                    ctrl.clear = 1'b1;
                    case (item.operation)
                        OP_WRITE:
                        begin
                            if (row_ok && other_ok)
                            begin
                                state_next = S_WRITE;
                            end
                        end
                        OP_FIRST:
                        begin
                            state_next = row_ok ? S_SCAN : S_DONE;
                        end
                        OP_NEXT:
                        begin
                            state_next = (row_ok && other_ok) ? S_FLOOR : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_FLOOR:
            begin
                n_next     = n_reg;
                state_next = S_FLOAD;
            end
            S_FLOAD:
            begin
                n_next          = n_reg;
                ctrl.load_floor = 1'b1;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                n_next  = n_reg;
                col_sel = col_reg;
                if (col_reg < n_reg)
                begin
                    pend_vld_next = (col_reg != {1'b0, item_reg.row_vertex});
                    pend_col_next = col_reg;
                    col_next      = col_reg + COL_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            col_reg      <= '0;
            pend_vld_reg <= 1'b0;
            pend_col_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            col_reg      <= col_next;
            pend_vld_reg <= pend_vld_next;
            pend_col_reg <= pend_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign addr_full = FW'(item_reg.row_vertex) * FW'(MAX_VERTICES) + FW'(col_sel);
    assign mem_addr  = addr_full[AW-1:0];
    assign wdata_ext = 64'(item_reg.weight);

    armn_mem
        #(
            .DEPTH (CELLS),
            .AW    (AW),
            .DW    (WEIGHT_BITS)
        )
        u_mem
        (
            .clk   (clk),
            .we    (mem_we),
            .addr  (mem_addr),
            .wdata (wdata_ext[WEIGHT_BITS-1:0]),
            .rdata (mem_rdata)
        );

    armn_scan
        #(
            .WEIGHT_BITS (WEIGHT_BITS)
        )
        u_scan
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .rdata  (mem_rdata),
            .result (result)
        );

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result beat");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.neighbour == 6'd0))
        else $error("neighbour set without found");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (state_reg == S_SCAN))
        else $error("compare pending outside scan");

    a_write_only_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ($past(state_reg) == S_IDLE))
        else $error("write not right after accept");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import armn_pkg::*;

    localparam int LIMIT = 1_000_000;

    class neighbour_scoreboard;
        bit [31:0] weights [64][64];
        int unsigned vertex_limit;
        out_item_t expected_q[$];
        int errors;
        int writes;
        int queries;

        function new();
            vertex_limit = 64;
            errors = 0;
            writes = 0;
            queries = 0;
        endfunction

        function void set_vertex_count(logic [COL_W-1:0] value);
            vertex_limit = value;
        endfunction

        // lightest column of row, skipping the diagonal; all-ones never qualifies
        function out_item_t lightest(logic [5:0] row, bit has_floor, logic [31:0] threshold);
            out_item_t res;
            int unsigned n;
            logic [31:0] best;
            res = '0;
            best = '1;
            n = (vertex_limit > 64) ? 64 : vertex_limit;
            for (int i = 0; i < n; i++)
            begin
                if (i == row)
                    continue;
                if (has_floor && !(weights[row][i] > threshold))
                    continue;
                if (weights[row][i] < best)
                begin
                    best = weights[row][i];
                    res.neighbour = i[5:0];
                    res.found = 1'b1;
                end
            end
            return res;
        endfunction

        function void note_item(in_item_t it);
            case (op_e'(it.operation))
                OP_WRITE:
                begin
                    weights[it.row_vertex][it.other_vertex] = it.weight;
                    writes++;
                end
                OP_FIRST:
                begin
                    expected_q.push_back(lightest(it.row_vertex, 1'b0, '0));
                    queries++;
                end
                OP_NEXT:
                begin
                    expected_q.push_back(lightest(it.row_vertex, 1'b1,
                        weights[it.row_vertex][it.other_vertex]));
                    queries++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: neighbour %0d found %0b", got.neighbour, got.found);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.neighbour !== exp.neighbour)
            begin
                $error("neighbour: expected %0d, got %0d", exp.neighbour, got.neighbour);
                errors++;
            end
            if (got.found !== exp.found)
            begin
                $error("found: expected %0b, got %0b", exp.found, got.found);
                errors++;
            end
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
            begin
                $error("%0d queries never answered", expected_q.size());
                errors += expected_q.size();
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    in_item_t         item;
    logic             done;
    out_item_t        result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [COL_W-1:0] cfg_data;

    neighbour_scoreboard sb = new();
    bit          written [64][64];
    int unsigned cur_count;
    int          sent_items;
    int          settings;
    int          cycles = 0;
    bit          no_idle;
    int          big_rows [4] = '{0, 21, 42, 63};

    adjacency_row_min_neighbour_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // entered and left just after a falling edge
    task automatic send_item(input in_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
        if (it.operation != OP_NONE)
            sent_items++;
        @(negedge clk);
    endtask

    task automatic put(input op_e op, input int row, input int col, input logic [31:0] w);
        in_item_t it;
        it.operation = op;
        it.row_vertex = row[5:0];
        it.other_vertex = col[5:0];
        it.weight = w;
        send_item(it);
    endtask

    task automatic write_cell(input int row, input int col, input logic [31:0] w);
        put(OP_WRITE, row, col, w);
        written[row][col] = 1'b1;
    endtask

    function automatic logic [31:0] pick_weight();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 5)
            return $urandom_range(0, 7);
        if (sel == 5)
            return '1;
        if (sel == 6)
            return 32'hFFFF_FFFE;
        if (sel == 7)
            return '0;
        return $urandom();
    endfunction

    // make sure a scan of this row touches only written cells
    task automatic fill_row(input int row);
        int n;
        n = (cur_count > 64) ? 64 : cur_count;
        for (int i = 0; i < n; i++)
        begin
            if (i != row && !written[row][i])
                write_cell(row, i, pick_weight());
        end
    endtask

    task automatic ask_first(input int row);
        fill_row(row);
        put(OP_FIRST, row, $urandom_range(0, 63), $urandom());
    endtask

    task automatic ask_next(input int row, input int refcol);
        fill_row(row);
        if (!written[row][refcol])
            write_cell(row, refcol, pick_weight());
        put(OP_NEXT, row, refcol, $urandom());
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0 || busy);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_vertex_count(input int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[6:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_vertex_count(v[6:0]);
        cur_count = v;
        settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // rewrite up to three cells of one row, then query it one to four times
    task automatic run_sequence();
        int n;
        int row;
        n = (cur_count > 64) ? 64 : cur_count;
        if (n > 16)
            row = big_rows[$urandom_range(0, 3)];
        else if (n > 0 && $urandom_range(0, 2) != 0)
            row = $urandom_range(0, n - 1);
        else
            row = $urandom_range(0, 63);
        repeat ($urandom_range(0, 3))
            write_cell(row, (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63),
                       pick_weight());
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 2) == 0)
                ask_first(row);
            else if (n == 0 || $urandom_range(0, 3) == 0)
                ask_next(row, $urandom_range(0, 63));
            else
                ask_next(row, $urandom_range(0, n - 1));
        end
    endtask

    initial
    begin
        int base;
        int quota;
        int phase;
        int unsigned v;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        cur_count = 64;
        sent_items = 0;
        settings = 0;
        no_idle = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ties, self column, no-edge weight, reference outside the scanned range
        set_vertex_count(5);
        write_cell(2, 0, 7);
        write_cell(2, 1, 3);
        write_cell(2, 2, 0);
        write_cell(2, 3, 3);
        write_cell(2, 4, '1);
        write_cell(2, 10, 5);
        put(OP_FIRST, 2, 0, 0);
        put(OP_NEXT, 2, 1, 0);
        put(OP_NEXT, 2, 0, 0);
        put(OP_NEXT, 2, 4, '1);
        put(OP_NEXT, 2, 2, 0);
        put(OP_NEXT, 2, 10, 0);
        put(OP_NONE, 63, 63, '1);
        write_cell(63, 0, 0);
        write_cell(63, 1, '1);
        write_cell(63, 2, '1);
        write_cell(63, 3, '1);
        write_cell(63, 4, 32'hFFFF_FFFE);
        put(OP_FIRST, 63, 63, '1);
        write_cell(63, 0, '1);
        put(OP_FIRST, 63, 0, 0);
        set_vertex_count(0);
        put(OP_FIRST, 2, 0, 0);
        put(OP_NEXT, 2, 1, 0);

        base = sent_items;
        phase = 0;
        while (sent_items - base < 1100)
        begin
            case (phase)
                0: v = 127;
                1: v = 64;
                2: v = 1;
                default:
                begin
                    case ($urandom_range(0, 19))
                        0: v = 0;
                        1: v = $urandom_range(65, 127);
                        2, 3: v = $urandom_range(13, 64);
                        default: v = $urandom_range(2, 12);
                    endcase
                end
            endcase
            set_vertex_count(v);
            no_idle = ($urandom_range(0, 3) == 0);
            quota = sent_items + $urandom_range(40, 120);
            while (sent_items < quota)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        put(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
                    else
                        write_cell($urandom_range(0, 63), $urandom_range(0, 63), pick_weight());
                end
                else
                    run_sequence();
                if ($urandom_range(0, 29) == 0)
                    drain();
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        sb.close_out();
        $display("Run covered %0d weight writes and %0d row queries", sb.writes, sb.queries);
        $display("across %0d vertex count settings, including 0, 1, 64 and 127", settings);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
